/* rtl/core/bfpr_pkg.sv */
// ----------------------------------------------------------------------------
// bfpr_pkg
// Shared types and constants of the bracket framed packet receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfpr_pkg;

    localparam int BUF_SIZE = 64;
    localparam int DEST_W   = 16;

    localparam logic [7:0] OPEN_MARK  = 8'h5B;  // '['
    localparam logic [7:0] CLOSE_MARK = 8'h5D;  // ']'

    typedef enum logic [1:0] {
        CMD_BYTE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // classified beat handed from the front end to the back end
    typedef struct packed {
        t_cmd              kind;
        logic              is_open;
        logic              is_close;
        logic [7:0]        rx_data;
        logic              dest_zero;
        logic [DEST_W-1:0] dest_m1;
    } t_item;

endpackage

`default_nettype wire

/* rtl/core/bfpr_in_if.sv */
// ----------------------------------------------------------------------------
// bfpr_in_if
// Input channel: command beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfpr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  rx_data;
    logic [15:0] dest_size;

    modport source (output valid, output cmd, output rx_data, output dest_size,
                    input ready);
    modport sink   (input valid, input cmd, input rx_data, input dest_size,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/bfpr_out_if.sv */
// ----------------------------------------------------------------------------
// bfpr_out_if
// Output channel: result beats with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       got_packet;
    logic       last;
    logic       packet_ready;

    modport source (output valid, output payload_byte, output got_packet,
                    output last, output packet_ready, input ready);
    modport sink   (input valid, input payload_byte, input got_packet,
                    input last, input packet_ready, output ready);
endinterface

`default_nettype wire

/* rtl/core/bfpr_ram.sv */
// ----------------------------------------------------------------------------
// bfpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/bfpr_front.sv */
// ----------------------------------------------------------------------------
// bfpr_front
// Accepts input beats and classifies them for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfpr_front (
    bfpr_in_if.sink                i_in,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output bfpr_pkg::t_item        o_item
);

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_item.kind      = bfpr_pkg::t_cmd'(i_in.cmd);
        o_item.is_open   = (i_in.rx_data == bfpr_pkg::OPEN_MARK);
        o_item.is_close  = (i_in.rx_data == bfpr_pkg::CLOSE_MARK);
        o_item.rx_data   = i_in.rx_data;
        o_item.dest_zero = (i_in.dest_size == '0);
        // wraps on zero; only used when dest_zero is clear
        o_item.dest_m1   = i_in.dest_size - bfpr_pkg::DEST_W'(1);
    end

endmodule

`default_nettype wire

/* rtl/core/bfpr_queue.sv */
// ----------------------------------------------------------------------------
// bfpr_queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfpr_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire bfpr_pkg::t_item   i_item,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output bfpr_pkg::t_item        o_item
);

    bfpr_pkg::t_item r_slot [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bfpr_back.sv */
// ----------------------------------------------------------------------------
// bfpr_back
// Carries out classified beats: framing state, payload store, read-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfpr_back #(
    parameter int BUF_SIZE = bfpr_pkg::BUF_SIZE
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire bfpr_pkg::t_item   i_item,
    output logic                   o_pop,
    bfpr_out_if.source             o_out
);

    localparam int IDX_W = $clog2(BUF_SIZE);
    localparam logic [IDX_W-1:0] FILL_MAX = IDX_W'(BUF_SIZE - 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state           r_state, n_state;
    logic             r_collect, n_collect;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic             r_flag, n_flag;
    logic [IDX_W-1:0] r_len, n_len;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_lim, n_lim;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_got, n_out_got;
    logic             r_out_last, n_out_last;
    logic             r_out_rdy, n_out_rdy;

    logic             free;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic [bfpr_pkg::DEST_W-1:0] len_ext;

    bfpr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (i_item.rx_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign free    = !r_out_valid || o_out.ready;
    assign len_ext = bfpr_pkg::DEST_W'(r_len);

    assign o_out.valid        = r_out_valid;
    assign o_out.payload_byte = r_out_byte;
    assign o_out.got_packet   = r_out_got;
    assign o_out.last         = r_out_last;
    assign o_out.packet_ready = r_out_rdy;

    always_comb begin
        n_state     = r_state;
        n_collect   = r_collect;
        n_fill      = r_fill;
        n_flag      = r_flag;
        n_len       = r_len;
        n_idx       = r_idx;
        n_lim       = r_lim;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_got   = r_out_got;
        n_out_last  = r_out_last;
        n_out_rdy   = r_out_rdy;
        o_pop       = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_q_valid && free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = 8'h00;
                    n_out_got   = 1'b0;
                    n_out_last  = 1'b1;
                    case (i_item.kind)
                        bfpr_pkg::CMD_BYTE: begin
                            if (!r_collect) begin
                                if (i_item.is_open && !r_flag) begin
                                    n_collect = 1'b1;
                                    n_fill    = '0;
                                end
                            end else if (i_item.is_close) begin
                                n_len     = r_fill;
                                n_flag    = 1'b1;
                                n_collect = 1'b0;
                            end else if (r_fill < FILL_MAX) begin
                                wr_en  = 1'b1;
                                n_fill = r_fill + IDX_W'(1);
                            end
                        end
                        bfpr_pkg::CMD_READ: begin
                            if (r_flag && !i_item.dest_zero) begin
                                // no beat yet: first byte arrives from the store
                                n_out_valid = r_out_valid && !o_out.ready;
                                n_out_byte  = r_out_byte;
                                n_out_got   = r_out_got;
                                n_out_last  = r_out_last;
                                n_flag      = 1'b0;
                                n_idx       = '0;
                                rd_addr     = '0;
                                n_lim       = (i_item.dest_m1 < len_ext) ?
                                              i_item.dest_m1[IDX_W-1:0] : r_len;
                                n_state     = ST_READ;
                            end
                        end
                        bfpr_pkg::CMD_CLEAR: begin
                            n_flag = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                    n_out_rdy = n_flag;
                end
            end
            ST_READ: begin
                if (free) begin
                    n_out_valid = 1'b1;
                    n_out_got   = 1'b1;
                    n_out_rdy   = 1'b0;
                    if (r_idx == r_lim || rd_data == 8'h00) begin
                        // terminator beat
                        n_out_byte = 8'h00;
                        n_out_last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        n_out_byte = rd_data;
                        n_out_last = 1'b0;
                        n_idx      = r_idx + IDX_W'(1);
                        rd_addr    = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_collect   <= 1'b0;
            r_fill      <= '0;
            r_flag      <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_collect   <= n_collect;
            r_fill      <= n_fill;
            r_flag      <= n_flag;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_lim      <= n_lim;
        r_out_byte <= n_out_byte;
        r_out_got  <= n_out_got;
        r_out_last <= n_out_last;
        r_out_rdy  <= n_out_rdy;
    end

endmodule

`default_nettype wire

/* rtl/core/bracket_framed_packet_receiver_top.sv */
// ----------------------------------------------------------------------------
// bracket_framed_packet_receiver_top
// Frames received bytes into [payload] packets and reads them out.
// ----------------------------------------------------------------------------
// Input channel i_in carries one command per beat: a received byte, a read
// of the waiting packet, or a clear of the ready flag. Output channel o_out
// returns result beats; the final beat of each command has last set, and
// every beat carries the ready flag as it stands after that command.
// Byte and clear commands each give one status beat via the queue and the
// output register, taken at one per cycle while o_out.ready is high and no
// read runs. A read of a waiting packet gives up to dest_size-1 of its bytes,
// one per cycle while o_out.ready is high, out of the registered read port
// of the payload RAM, then a terminator beat. Reads are handled one at a
// time; up to two further commands queue up behind a read meanwhile.
// When o_out.ready is low the output register holds its beat, the back end
// stops, and the two-entry queue fills before i_in.ready drops.
// Reset clears the framing state and the ready flag; the payload RAM is not
// cleared, since only bytes written for the current packet are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bracket_framed_packet_receiver_top #(
    parameter int BUF_SIZE = bfpr_pkg::BUF_SIZE
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bfpr_in_if.sink    i_in,
    bfpr_out_if.source o_out
);

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            pop;
    bfpr_pkg::t_item front_item;
    bfpr_pkg::t_item back_item;

    bfpr_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (front_item)
    );

    bfpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (back_item)
    );

    bfpr_back #(
        .BUF_SIZE (BUF_SIZE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (back_item),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
